[hdl/ssmp_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ssmp_pkg
// Shared types and constants for the startup message parser.
// ----------------------------------------------------------------------------
package ssmp_pkg;

    // Record kinds on the result channel
    localparam logic [2:0] REC_LENGTH   = 3'd0;
    localparam logic [2:0] REC_TYPE     = 3'd1;
    localparam logic [2:0] REC_VERSION  = 3'd2;
    localparam logic [2:0] REC_USER     = 3'd3;
    localparam logic [2:0] REC_USER_END = 3'd4;
    localparam logic [2:0] REC_DB       = 3'd5;
    localparam logic [2:0] REC_DB_END   = 3'd6;
    localparam logic [2:0] REC_ABORT    = 3'd7;

    // Message types
    localparam logic [2:0] MSG_STARTUP = 3'd0;
    localparam logic [2:0] MSG_SSL     = 3'd1;
    localparam logic [2:0] MSG_CANCEL  = 3'd2;
    localparam logic [2:0] MSG_GSS     = 3'd3;
    localparam logic [2:0] MSG_UNKNOWN = 3'd4;

    // Protocol word codes
    localparam logic [15:0] SPECIAL_MAJOR = 16'd1234;
    localparam logic [15:0] CODE_SSL      = 16'd5679;
    localparam logic [15:0] CODE_CANCEL   = 16'd5678;
    localparam logic [15:0] CODE_GSS      = 16'd5680;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

    // Up to three records caused by one input byte
    typedef struct packed {
        logic [1:0]       count;
        logic [2:0][2:0]  kind;
        logic [31:0]      length;
        logic [2:0]       msg_type;
        logic [15:0]      major;
        logic [15:0]      minor;
        logic [7:0]       value;
    } ssmp_bundle_t;

    // Characters of the name "user"
    function automatic logic [7:0] user_char(input logic [1:0] pos);
        logic [7:0] c;
        case (pos)
            2'd0:    c = 8'h75;
            2'd1:    c = 8'h73;
            2'd2:    c = 8'h65;
            default: c = 8'h72;
        endcase
        return c;
    endfunction

    // Characters of the name "database"
    function automatic logic [7:0] db_char(input logic [2:0] pos);
        logic [7:0] c;
        case (pos)
            3'd0:    c = 8'h64;
            3'd1:    c = 8'h61;
            3'd2:    c = 8'h74;
            3'd3:    c = 8'h61;
            3'd4:    c = 8'h62;
            3'd5:    c = 8'h61;
            3'd6:    c = 8'h73;
            default: c = 8'h65;
        endcase
        return c;
    endfunction

endpackage
`default_nettype wire

[hdl/ssmp_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ssmp_front
// Accepts payload bytes, tracks the parse and builds one record bundle per byte.
// ----------------------------------------------------------------------------
module ssmp_front
    import ssmp_pkg::*;
#(
    parameter int MAX_PAIRS  = 16,
    parameter int VALUE_KEEP = 191
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         accept,
    input  wire logic [7:0]   data_byte,
    input  wire logic         last_byte,
    output ssmp_bundle_t      bundle,
    output logic              push
);

    localparam int VCW = $clog2(VALUE_KEEP + 1);
    localparam int PCW = $clog2(MAX_PAIRS + 1);

    localparam logic [2:0] PH_HEADER = 3'd0;
    localparam logic [2:0] PH_NAME   = 3'd1;
    localparam logic [2:0] PH_VUSER  = 3'd2;
    localparam logic [2:0] PH_VDB    = 3'd3;
    localparam logic [2:0] PH_VOTHER = 3'd4;
    localparam logic [2:0] PH_DONE   = 3'd5;

    logic [2:0]     phase_reg, phase_next;
    logic [2:0]     hcount_reg, hcount_next;
    logic [55:0]    shift_reg, shift_next;
    logic [3:0]     npos_reg, npos_next;
    logic [1:0]     flags_reg, flags_next;
    logic [VCW-1:0] vcount_reg, vcount_next;
    logic [PCW-1:0] pairs_reg, pairs_next;

    // Decode one byte into state updates and records
    always_comb begin
        logic [63:0] hdr;
        logic [1:0]  n;
        logic        keep;
        logic [2:0]  base;
        phase_next  = phase_reg;
        hcount_next = hcount_reg;
        shift_next  = shift_reg;
        npos_next   = npos_reg;
        flags_next  = flags_reg;
        vcount_next = vcount_reg;
        pairs_next  = pairs_reg;
        bundle      = '0;
        hdr         = {shift_reg, data_byte};
        n           = 2'd0;
        keep        = (phase_reg == PH_VUSER) || (phase_reg == PH_VDB);
        base        = (phase_reg == PH_VUSER) ? REC_USER : REC_DB;

        if (accept) begin
            case (phase_reg)
                PH_HEADER: begin
                    shift_next  = hdr[55:0];
                    hcount_next = hcount_reg + 3'd1;
                    if (hcount_reg == 3'd7) begin
                        bundle.length  = hdr[63:32];
                        bundle.kind[0] = REC_LENGTH;
                        bundle.kind[1] = REC_TYPE;
                        if (hdr[31:16] == SPECIAL_MAJOR) begin
                            bundle.count = 2'd2;
                            if (hdr[15:0] == CODE_SSL) begin
                                bundle.msg_type = MSG_SSL;
                            end else if (hdr[15:0] == CODE_CANCEL) begin
                                bundle.msg_type = MSG_CANCEL;
                            end else if (hdr[15:0] == CODE_GSS) begin
                                bundle.msg_type = MSG_GSS;
                            end else begin
                                bundle.msg_type = MSG_UNKNOWN;
                            end
                            phase_next = PH_DONE;
                        end else begin
                            bundle.count    = 2'd3;
                            bundle.msg_type = MSG_STARTUP;
                            bundle.kind[2]  = REC_VERSION;
                            bundle.major    = hdr[31:16];
                            bundle.minor    = hdr[15:0];
                            pairs_next      = '0;
                            npos_next       = 4'd0;
                            flags_next      = 2'b11;
                            vcount_next     = '0;
                            phase_next      = PH_NAME;
                        end
                    end
                end
                PH_NAME: begin
                    if (data_byte == 8'd0) begin
                        if (npos_reg == 4'd0) begin
                            phase_next = PH_DONE;
                        end else if (flags_reg[0] && npos_reg == 4'd4) begin
                            phase_next = PH_VUSER;
                        end else if (flags_reg[1] && npos_reg == 4'd8) begin
                            phase_next = PH_VDB;
                        end else begin
                            phase_next = PH_VOTHER;
                        end
                        vcount_next = '0;
                    end else begin
                        if (npos_reg >= 4'd4 || data_byte != user_char(npos_reg[1:0])) begin
                            flags_next[0] = 1'b0;
                        end
                        if (npos_reg >= 4'd8 || data_byte != db_char(npos_reg[2:0])) begin
                            flags_next[1] = 1'b0;
                        end
                        if (npos_reg != 4'd15) begin
                            npos_next = npos_reg + 4'd1;
                        end
                    end
                end
                PH_VUSER, PH_VDB, PH_VOTHER: begin
                    if (data_byte == 8'd0) begin
                        if (keep) begin
                            bundle.kind[0] = base + 3'd1;
                            bundle.count   = 2'd1;
                        end
                        pairs_next  = pairs_reg + PCW'(1);
                        npos_next   = 4'd0;
                        flags_next  = 2'b11;
                        vcount_next = '0;
                        phase_next  = (pairs_next >= PCW'(MAX_PAIRS)) ? PH_DONE : PH_NAME;
                    end else begin
                        if (keep && vcount_reg < VCW'(VALUE_KEEP)) begin
                            bundle.kind[n] = base;
                            bundle.value   = data_byte;
                            vcount_next    = vcount_reg + VCW'(1);
                            n              = n + 2'd1;
                        end
                        if (keep && last_byte) begin
                            bundle.kind[n] = REC_ABORT;
                            n              = n + 2'd1;
                        end
                        bundle.count = n;
                    end
                end
                default: begin
                end
            endcase

            // Return to reset after the final byte
            if (last_byte) begin
                phase_next  = PH_HEADER;
                hcount_next = 3'd0;
                shift_next  = '0;
                npos_next   = 4'd0;
                flags_next  = 2'b11;
                vcount_next = '0;
                pairs_next  = '0;
            end
        end
    end

    assign push = accept && (bundle.count != 2'd0);

    // Parse state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_HEADER;
            hcount_reg <= 3'd0;
            shift_reg  <= '0;
            npos_reg   <= 4'd0;
            flags_reg  <= 2'b11;
            vcount_reg <= '0;
            pairs_reg  <= '0;
        end else begin
            phase_reg  <= phase_next;
            hcount_reg <= hcount_next;
            shift_reg  <= shift_next;
            npos_reg   <= npos_next;
            flags_reg  <= flags_next;
            vcount_reg <= vcount_next;
            pairs_reg  <= pairs_next;
        end
    end

endmodule
`default_nettype wire

[hdl/ssmp_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ssmp_queue
// Short FIFO of record bundles between the front and the back.
// ----------------------------------------------------------------------------
module ssmp_queue
    import ssmp_pkg::*;
(
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          push,
    input  wire ssmp_bundle_t  wr_data,
    output logic               full,
    input  wire logic          pop,
    output ssmp_bundle_t       rd_data,
    output logic               not_empty
);

    ssmp_bundle_t          entry_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   wptr_reg, rptr_reg;
    logic [QUEUE_AW:0]     fill_reg, fill_next;

    assign full      = (fill_reg == (QUEUE_AW + 1)'(QUEUE_DEPTH));
    assign not_empty = (fill_reg != '0);
    assign rd_data   = entry_reg[rptr_reg];

    always_comb begin
        fill_next = fill_reg;
        if (push && !pop) begin
            fill_next = fill_reg + 1'b1;
        end else if (pop && !push) begin
            fill_next = fill_reg - 1'b1;
        end
    end

    // Store bundles
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wptr_reg] <= wr_data;
        end
    end

    // Advance pointers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            fill_reg <= '0;
        end else begin
            if (push) begin
                wptr_reg <= wptr_reg + 1'b1;
            end
            if (pop) begin
                rptr_reg <= rptr_reg + 1'b1;
            end
            fill_reg <= fill_next;
        end
    end

endmodule
`default_nettype wire

[hdl/ssmp_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ssmp_back
// Unpacks bundles into single records and drives the registered result port.
// ----------------------------------------------------------------------------
module ssmp_back
    import ssmp_pkg::*;
(
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire ssmp_bundle_t  head,
    input  wire logic          head_valid,
    output logic               pop,
    output logic               m_valid,
    input  wire logic          m_ready,
    output logic [2:0]         m_record_kind,
    output logic [31:0]        m_message_length,
    output logic [2:0]         m_message_type,
    output logic [15:0]        m_version_major,
    output logic [15:0]        m_version_minor,
    output logic [7:0]         m_value_byte,
    output logic               m_run_last
);

    logic        load;
    logic        final_rec;
    logic [1:0]  idx_reg;
    logic [2:0]  kind;
    logic        valid_reg;
    logic [2:0]  kind_reg;
    logic [31:0] len_reg;
    logic [2:0]  type_reg;
    logic [15:0] major_reg, minor_reg;
    logic [7:0]  value_reg;
    logic        last_reg;

    assign load      = head_valid && (!valid_reg || m_ready);
    assign kind      = head.kind[idx_reg];
    assign final_rec = (idx_reg == head.count - 2'd1);
    assign pop       = load && final_rec;

    // Walk records within the head bundle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg   <= 2'd0;
            valid_reg <= 1'b0;
        end else begin
            if (load) begin
                idx_reg <= final_rec ? 2'd0 : idx_reg + 2'd1;
            end
            if (load) begin
                valid_reg <= 1'b1;
            end else if (m_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    // Hold the output transaction, zero fields not tied to its kind
    always_ff @(posedge aclk) begin
        if (load) begin
            kind_reg  <= kind;
            len_reg   <= (kind == REC_LENGTH) ? head.length : 32'd0;
            type_reg  <= (kind == REC_TYPE) ? head.msg_type : 3'd0;
            major_reg <= (kind == REC_VERSION) ? head.major : 16'd0;
            minor_reg <= (kind == REC_VERSION) ? head.minor : 16'd0;
            value_reg <= (kind == REC_USER || kind == REC_DB) ? head.value : 8'd0;
            last_reg  <= final_rec;
        end
    end

    assign m_valid          = valid_reg;
    assign m_record_kind    = kind_reg;
    assign m_message_length = len_reg;
    assign m_message_type   = type_reg;
    assign m_version_major  = major_reg;
    assign m_version_minor  = minor_reg;
    assign m_value_byte     = value_reg;
    assign m_run_last       = last_reg;

endmodule
`default_nettype wire

[hdl/sql_startup_message_parser_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sql_startup_message_parser_top
// Startup message parser: length, type, version and user/database values.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one payload byte per transaction, s_last_byte on the final
//   byte. Parse state returns to its initial state after that byte.
//   m_ channel: one record per transaction; m_run_last marks the final
//   record caused by an input byte. Bytes causing no record yield nothing.
// Path: each byte's bundle is written into the queue, and its records are
//   then registered one at a time at the back's output; with the output
//   free, further records of the same byte follow one per cycle.
// Throughput: one byte per cycle while the queue is not full. The back
//   emits one record per cycle with the output free; the header byte (three
//   records) and a last value byte (two) are absorbed by a four-bundle queue.
// Reset: synchronous, active low; queue emptied, parser at the header.
// Stall: while m_ready is low the output holds; s_ready drops only once
//   the queue is full.
// ----------------------------------------------------------------------------
module sql_startup_message_parser_top
    import ssmp_pkg::*;
#(
    parameter int MAX_PAIRS  = 16,
    parameter int VALUE_KEEP = 191
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire logic [7:0]    s_data_byte,
    input  wire logic          s_last_byte,
    output logic               m_valid,
    input  wire logic          m_ready,
    output logic [2:0]         m_record_kind,
    output logic [31:0]        m_message_length,
    output logic [2:0]         m_message_type,
    output logic [15:0]        m_version_major,
    output logic [15:0]        m_version_minor,
    output logic [7:0]         m_value_byte,
    output logic               m_run_last
);

    ssmp_bundle_t wr_bundle;
    ssmp_bundle_t head;
    logic         push;
    logic         pop;
    logic         full;
    logic         head_valid;
    logic         accept;

    assign s_ready = !full;
    assign accept  = s_valid && s_ready;

    ssmp_front #(
        .MAX_PAIRS  (MAX_PAIRS),
        .VALUE_KEEP (VALUE_KEEP)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (accept),
        .data_byte (s_data_byte),
        .last_byte (s_last_byte),
        .bundle    (wr_bundle),
        .push      (push)
    );

    ssmp_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .wr_data   (wr_bundle),
        .full      (full),
        .pop       (pop),
        .rd_data   (head),
        .not_empty (head_valid)
    );

    ssmp_back u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .head             (head),
        .head_valid       (head_valid),
        .pop              (pop),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_record_kind    (m_record_kind),
        .m_message_length (m_message_length),
        .m_message_type   (m_message_type),
        .m_version_major  (m_version_major),
        .m_version_minor  (m_version_minor),
        .m_value_byte     (m_value_byte),
        .m_run_last       (m_run_last)
    );

    // A full queue always has a record waiting at the output
    assert property (@(posedge aclk) disable iff (!aresetn) !s_ready |-> m_valid)
        else $error("queue full without a pending output record");

    // An abort record always closes the records of its byte
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_record_kind == REC_ABORT) |-> m_run_last)
        else $error("abort record not marked last");

    // Length field is zero outside length records
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_record_kind != REC_LENGTH) |-> (m_message_length == 32'd0))
        else $error("length field set on a non-length record");

    // Reset leaves no record pending
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("output valid right after reset");

endmodule
`default_nettype wire

[bench/sql_startup_message_parser_top_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sql_startup_message_parser_top_test
// Self-checking bench for the startup message parser. Payloads are built as
// byte strings (startup messages with name/value pairs, special requests,
// short and noisy payloads) and streamed in one byte per transaction. A
// scoreboard predicts the records of every accepted byte and checks each
// accepted record in order, under random idling on both channels and one
// long output hold-off.
// ----------------------------------------------------------------------------
module sql_startup_message_parser_top_test;
    import ssmp_pkg::*;

    localparam int MAX_PAIRS   = 16;
    localparam int VALUE_KEEP  = 191;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES = 20;

    typedef enum logic [2:0] {
        ST_HEADER, ST_NAME, ST_VUSER, ST_VDB, ST_VOTHER, ST_DONE
    } parse_state_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] length;
        logic [2:0]  msg_type;
        logic [15:0] major;
        logic [15:0] minor;
        logic [7:0]  value;
        logic        run_last;
    } parser_rec_t;

    // Predict records per byte and match them against the output stream
    class record_scoreboard;
        parser_rec_t  expected_q[$];
        int           errors;
        parse_state_t state;
        int           hdr_count;
        logic [63:0]  hdr_shift;
        int           name_pos;
        logic         user_ok;
        logic         db_ok;
        int           value_count;
        int           pair_count;
        string        user_word = "user";
        string        db_word = "database";

        function void clear_parse();
            state = ST_HEADER;
            hdr_count = 0;
            hdr_shift = '0;
            name_pos = 0;
            user_ok = 1'b1;
            db_ok = 1'b1;
            value_count = 0;
            pair_count = 0;
        endfunction

        function void open_name();
            name_pos = 0;
            user_ok = 1'b1;
            db_ok = 1'b1;
            value_count = 0;
            state = (pair_count >= MAX_PAIRS) ? ST_DONE : ST_NAME;
        endfunction

        function parser_rec_t make_rec(logic [2:0] kind, logic [31:0] len, logic [2:0] mt,
                                       logic [15:0] maj, logic [15:0] mnr, logic [7:0] vb);
            parser_rec_t r;
            r.kind = kind;
            r.length = len;
            r.msg_type = mt;
            r.major = maj;
            r.minor = mnr;
            r.value = vb;
            r.run_last = 1'b0;
            return r;
        endfunction

        // Note one accepted input transaction
        function void note_byte(logic [7:0] b, logic last);
            parser_rec_t step_q[$];
            parser_rec_t r;
            logic [15:0] maj;
            logic [15:0] mnr;
            logic [2:0]  mt;
            logic        keep;
            logic [2:0]  byte_kind;
            logic [2:0]  end_kind;
            case (state)
                ST_HEADER: begin
                    hdr_shift = {hdr_shift[55:0], b};
                    hdr_count++;
                    if (hdr_count >= 8) begin
                        hdr_count = 8;
                        maj = hdr_shift[31:16];
                        mnr = hdr_shift[15:0];
                        step_q.push_back(make_rec(REC_LENGTH, hdr_shift[63:32], 3'd0,
                                                  16'd0, 16'd0, 8'd0));
                        if (maj == SPECIAL_MAJOR) begin
                            if (mnr == CODE_SSL) mt = MSG_SSL;
                            else if (mnr == CODE_CANCEL) mt = MSG_CANCEL;
                            else if (mnr == CODE_GSS) mt = MSG_GSS;
                            else mt = MSG_UNKNOWN;
                            step_q.push_back(make_rec(REC_TYPE, 32'd0, mt, 16'd0, 16'd0, 8'd0));
                            state = ST_DONE;
                        end else begin
                            step_q.push_back(make_rec(REC_TYPE, 32'd0, MSG_STARTUP,
                                                      16'd0, 16'd0, 8'd0));
                            step_q.push_back(make_rec(REC_VERSION, 32'd0, 3'd0, maj, mnr, 8'd0));
                            pair_count = 0;
                            open_name();
                        end
                    end
                end
                ST_NAME: begin
                    if (b == 8'd0) begin
                        if (name_pos == 0) state = ST_DONE;
                        else if (user_ok && name_pos == 4) state = ST_VUSER;
                        else if (db_ok && name_pos == 8) state = ST_VDB;
                        else state = ST_VOTHER;
                        value_count = 0;
                    end else begin
                        if (name_pos >= 4 || b != user_word[name_pos]) user_ok = 1'b0;
                        if (name_pos >= 8 || b != db_word[name_pos]) db_ok = 1'b0;
                        // Saturate so that overlong names match nothing
                        if (name_pos < 15) name_pos++;
                    end
                end
                ST_VUSER, ST_VDB, ST_VOTHER: begin
                    keep = (state != ST_VOTHER);
                    byte_kind = (state == ST_VUSER) ? REC_USER : REC_DB;
                    end_kind = (state == ST_VUSER) ? REC_USER_END : REC_DB_END;
                    if (b == 8'd0) begin
                        if (keep)
                            step_q.push_back(make_rec(end_kind, 32'd0, 3'd0, 16'd0, 16'd0, 8'd0));
                        pair_count++;
                        open_name();
                    end else begin
                        // Drop value bytes past the keep limit
                        if (keep && value_count < VALUE_KEEP) begin
                            step_q.push_back(make_rec(byte_kind, 32'd0, 3'd0, 16'd0, 16'd0, b));
                            value_count++;
                        end
                        if (keep && last)
                            step_q.push_back(make_rec(REC_ABORT, 32'd0, 3'd0, 16'd0, 16'd0, 8'd0));
                    end
                end
                default: ;
            endcase
            // Flag the final record of this byte
            if (step_q.size() > 0) begin
                r = step_q.pop_back();
                r.run_last = 1'b1;
                step_q.push_back(r);
            end
            foreach (step_q[i]) expected_q.push_back(step_q[i]);
            if (last) clear_parse();
        endfunction

        function void cmp_field(string fname, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, fname, want, got);
                errors++;
            end
        endfunction

        // Check one accepted output transaction against the oldest prediction
        function void check_record(parser_rec_t got);
            parser_rec_t want;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected record, expected none, actual kind %0h", $time,
                         got.kind);
                errors++;
            end else begin
                want = expected_q.pop_front();
                cmp_field("record_kind", want.kind, got.kind);
                cmp_field("message_length", want.length, got.length);
                cmp_field("message_type", want.msg_type, got.msg_type);
                cmp_field("version_major", want.major, got.major);
                cmp_field("version_minor", want.minor, got.minor);
                cmp_field("value_byte", want.value, got.value);
                cmp_field("run_last", want.run_last, got.run_last);
            end
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_data_byte = 8'd0;
    logic        s_last_byte = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [2:0]  m_record_kind;
    logic [31:0] m_message_length;
    logic [2:0]  m_message_type;
    logic [15:0] m_version_major;
    logic [15:0] m_version_minor;
    logic [7:0]  m_value_byte;
    logic        m_run_last;

    record_scoreboard sb;
    logic [7:0] msg_q[$];
    int         sent_bytes = 0;
    int         tx_idle_pct = 0;
    int         rx_idle_pct = 0;
    int         hold_requests = 0;

    sql_startup_message_parser_top #(
        .MAX_PAIRS (MAX_PAIRS),
        .VALUE_KEEP(VALUE_KEEP)
    ) uut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data_byte     (s_data_byte),
        .s_last_byte     (s_last_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_record_kind   (m_record_kind),
        .m_message_length(m_message_length),
        .m_message_type  (m_message_type),
        .m_version_major (m_version_major),
        .m_version_minor (m_version_minor),
        .m_value_byte    (m_value_byte),
        .m_run_last      (m_run_last)
    );

    always #5 aclk = ~aclk;

    // Observe both channels at the clock edge
    always @(posedge aclk) begin
        parser_rec_t got;
        if (aresetn) begin
            if (s_valid && s_ready) sb.note_byte(s_data_byte, s_last_byte);
            if (m_valid && m_ready) begin
                got = {m_record_kind, m_message_length, m_message_type, m_version_major,
                       m_version_minor, m_value_byte, m_run_last};
                sb.check_record(got);
            end
        end
    end

    // Drive the receiver: random stalls, plus a long hold-off on request
    initial begin
        int hold_left;
        int holds_served;
        hold_left = 0;
        holds_served = 0;
        forever begin
            @(posedge aclk);
            if (holds_served != hold_requests) begin
                holds_served = hold_requests;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
            end
        end
    end

    function automatic void add_word(logic [31:0] w);
        msg_q.push_back(w[31:24]);
        msg_q.push_back(w[23:16]);
        msg_q.push_back(w[15:8]);
        msg_q.push_back(w[7:0]);
    endfunction

    function automatic void add_text(string s);
        for (int i = 0; i < s.len(); i++) msg_q.push_back(s[i]);
    endfunction

    // Append n random non-NUL bytes
    function automatic void add_fill(int n);
        repeat (n) msg_q.push_back(8'($urandom_range(1, 255)));
    endfunction

    function automatic void add_startup_header();
        logic [15:0] maj;
        add_word($urandom_range(0, 1) ? 32'($urandom) : 32'($urandom_range(0, 300)));
        case ($urandom_range(0, 3))
            0:       maj = 16'd0;
            1:       maj = 16'd3;
            2:       maj = 16'hFFFF;
            default: maj = 16'($urandom);
        endcase
        // Keep startup headers away from the special-request marker
        if (maj == SPECIAL_MAJOR) maj = maj + 16'd1;
        add_word({maj, 16'($urandom)});
    endfunction

    // Append a parameter name: exact matches, near misses, random and overlong
    function automatic void add_name();
        case ($urandom_range(0, 9))
            0, 1, 2: add_text("user");
            3, 4, 5: add_text("database");
            6: begin
                if ($urandom_range(0, 1)) add_text("use");
                else add_text("databas");
            end
            7: begin
                if ($urandom_range(0, 1)) add_text("users");
                else add_text("databases");
            end
            8: add_fill($urandom_range(1, 5));
            default: begin
                if ($urandom_range(0, 1)) begin
                    add_text("database");
                    add_fill($urandom_range(8, 12));
                end else begin
                    add_fill($urandom_range(16, 20));
                end
            end
        endcase
    endfunction

    // Offer one input transaction, with random idle cycles ahead of it
    task automatic send_byte(logic [7:0] d, logic l);
        if ($urandom_range(0, 99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(0, 99) < tx_idle_pct);
        end
        s_valid <= 1'b1;
        s_data_byte <= d;
        s_last_byte <= l;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sent_bytes++;
    endtask

    // Stream the built payload, flagging its final byte
    task automatic send_message();
        foreach (msg_q[i]) send_byte(msg_q[i], i == msg_q.size() - 1);
        msg_q.delete();
    endtask

    // Stream random payloads until about target bytes have gone in
    task automatic send_random(int target);
        int start;
        int pick;
        int np;
        int ending;
        start = sent_bytes;
        while (sent_bytes - start < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                // Well-formed startup message, ended in one of several places
                add_startup_header();
                np = $urandom_range(0, 4);
                ending = $urandom_range(0, 5);
                if (ending != 0) begin
                    for (int p = 0; p < np; p++) begin
                        add_name();
                        msg_q.push_back(8'd0);
                        add_fill($urandom_range(0, 6));
                        msg_q.push_back(8'd0);
                    end
                    case (ending)
                        1: msg_q.push_back(8'd0);
                        2: begin
                            msg_q.push_back(8'd0);
                            repeat ($urandom_range(1, 3)) msg_q.push_back(8'($urandom));
                        end
                        3: add_fill($urandom_range(1, 3));
                        4: begin
                            add_name();
                            msg_q.push_back(8'd0);
                            add_fill($urandom_range(1, 4));
                        end
                        default: ;
                    endcase
                end
            end else if (pick < 85) begin
                // Special request with optional trailing bytes
                add_word($urandom);
                case ($urandom_range(0, 3))
                    0:       add_word({SPECIAL_MAJOR, CODE_SSL});
                    1:       add_word({SPECIAL_MAJOR, CODE_CANCEL});
                    2:       add_word({SPECIAL_MAJOR, CODE_GSS});
                    default: add_word({SPECIAL_MAJOR, 16'($urandom)});
                endcase
                repeat ($urandom_range(0, 3)) msg_q.push_back(8'($urandom));
            end else if (pick < 95) begin
                repeat ($urandom_range(1, 7)) msg_q.push_back(8'($urandom));
            end else begin
                repeat ($urandom_range(8, 20)) msg_q.push_back(8'($urandom));
            end
            send_message();
        end
    endtask

    // Bound the run
    initial begin
        #5_000_000;
        $display("sql_startup_message_parser_top verification failed");
        $finish;
    end

    initial begin
        sb = new;
        sb.clear_parse();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Sender idles often less than the receiver
        tx_idle_pct = 24;
        rx_idle_pct = 71;

        // Short payload: no record
        msg_q.push_back(8'h00);
        msg_q.push_back(8'hFF);
        send_message();
        // SSL request with the largest length, last flag on the header end
        add_word(32'hFFFF_FFFF);
        add_word({SPECIAL_MAJOR, CODE_SSL});
        send_message();
        // All-zero header, then a user value cut by the last byte
        add_word(32'd0);
        add_word(32'd0);
        add_text("user");
        msg_q.push_back(8'd0);
        msg_q.push_back(8'hFF);
        send_message();

        // One pair beyond the pair limit must be ignored; short names keep it brief
        add_startup_header();
        for (int p = 0; p < MAX_PAIRS; p++) begin
            add_fill(1);
            msg_q.push_back(8'd0);
            msg_q.push_back(8'd0);
        end
        add_text("user");
        msg_q.push_back(8'd0);
        add_fill(2);
        msg_q.push_back(8'd0);
        send_message();
        send_random(10);

        // Swap the idle rates
        tx_idle_pct = 71;
        rx_idle_pct = 24;
        send_random(20);

        // No idling; hold the receiver off while the sender keeps offering
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_requests++;
        // Database value, then a user value cut by the last byte
        add_startup_header();
        add_text("database");
        msg_q.push_back(8'd0);
        add_fill(6);
        msg_q.push_back(8'd0);
        add_text("user");
        msg_q.push_back(8'd0);
        add_fill(3);
        send_message();

        // Drain remaining records
        s_valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.errors == 0 && sb.expected_q.size() == 0) begin
            $display("sql_startup_message_parser_top verification clean");
        end else begin
            $display("sql_startup_message_parser_top verification failed");
        end
        $finish;
    end

endmodule
